/* hw/rtl/indexed_min_heap_timer_defines.svh */
// assertion macros for the timer queue checker
// no dependencies; expects clock and reset in the scope of use
`ifndef INDEXED_MIN_HEAP_TIMER_DEFINES_SVH
`define INDEXED_MIN_HEAP_TIMER_DEFINES_SVH

// consequent checked in the same cycle
`define IMHT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define IMHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/imht_pkg.sv */
// shared constants, types and command/status structs of the timer queue
// no dependencies
package imht_pkg;

   localparam int CAPACITY    = 64;
   localparam int ID_SPACE    = 1024;
   localparam int MS_W        = 32;
   localparam int TIME_BITS   = MS_W;
   localparam int MAX_RESULTS = 64;
   localparam int OP_W        = 3;
   localparam int KIND_W      = 2;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int ID_W        = $clog2(ID_SPACE);
   localparam int K_W         = $clog2(MAX_RESULTS + 1);
   localparam int ENTRY_W     = ID_W + TIME_BITS;

   typedef logic [ID_W-1:0]      id_type;
   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [K_W-1:0]       k_type;

   typedef struct packed {
      id_type   id;
      time_type exp;
   } entry_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 3'd0,
      OP_ADJUST = 3'd1,
      OP_FIRE   = 3'd2,
      OP_TICK   = 3'd3,
      OP_NEXT   = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_EVENT  = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_DONE   = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LK_HEAP, ST_LK_CHK, ST_RM_A, ST_RM_B,
      ST_DN_A, ST_DN_B, ST_DN_C, ST_DN_END, ST_UP_A, ST_UP_B,
      ST_FIN, ST_POST, ST_TK_RD, ST_TK_CK, ST_TK_END, ST_GN_RD, ST_GN_RP
   } state_type;

   typedef enum logic [2:0] {
      RD_POS, RD_J, RD_J1, RD_PAR, RD_ROOT, RD_TAIL
   } rd_sel_type;

   typedef enum logic [1:0] { WS_BEST, WS_PARENT, WS_X } wsrc_type;

   typedef enum logic [2:0] {
      I_HOLD, I_BEST, I_PAR, I_POS, I_CNT, I_ROOT
   } i_sel_type;

   typedef enum logic [1:0] { CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR } cnt_op_type;
   typedef enum logic { XS_REQ, XS_RDATA } xsrc_type;
   typedef enum logic [1:0] { ES_ZERO, ES_PEND, ES_REQ } esrc_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wsrc_type   wsrc;
      i_sel_type  i_sel;
      logic       start_ld;
      cnt_op_type cnt_op;
      logic       x_ld;
      xsrc_type   xsrc;
      logic       c_ld;
      logic       pos_ld;
      logic       k_clr;
      logic       k_inc;
      logic       pend_clr;
      logic       pend_ld;
      logic       emit;
      kind_type   kind;
      esrc_type   esrc;
      logic       rem_rep;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic present;
      logic full;
      logic tail;
      logic cnt_zero;
      logic cnt_gt1;
      logic j_ok;
      logic j1_ok;
      logic i_zero;
      logic child_win;
      logic parent_win;
      logic moved;
      logic due;
      logic k_ok;
      logic pend_v;
   } dp_status_type;

   // a before b as a signed difference
   function automatic logic earlier(time_type a, time_type b);
      time_type diff;
      diff = a - b;
      return diff[TIME_BITS-1];
   endfunction

endpackage

/* hw/rtl/imht_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module imht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/imht_ctrl.sv */
// sequencer of the timer queue: lookup, sift down/up, removal, tick loop
// depends on imht_pkg
module imht_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  imht_pkg::dp_status_type status,
   output imht_pkg::dp_cmd_type    cmd
);

   imht_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imht_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != imht_pkg::ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imht_pkg::ST_IDLE: begin
            if (start) state_in = imht_pkg::ST_LK_HEAP;
         end
         imht_pkg::ST_LK_HEAP: state_in = imht_pkg::ST_LK_CHK;
         imht_pkg::ST_LK_CHK: begin
            unique case (status.op) inside
               imht_pkg::OP_ADD: begin
                  if (status.present)   state_in = imht_pkg::ST_DN_A;
                  else if (status.full) state_in = imht_pkg::ST_IDLE;
                  else                  state_in = imht_pkg::ST_UP_A;
               end
               imht_pkg::OP_ADJUST: begin
                  if (status.present) state_in = imht_pkg::ST_DN_A;
                  else                state_in = imht_pkg::ST_IDLE;
               end
               imht_pkg::OP_FIRE: begin
                  // a slot map entry never written counts as absent
                  if (status.present) begin
                     if (status.tail) state_in = imht_pkg::ST_RM_A;
                     else             state_in = imht_pkg::ST_POST;
                  end else begin
                     state_in = imht_pkg::ST_IDLE;
                  end
               end
               imht_pkg::OP_TICK, imht_pkg::OP_NEXT: state_in = imht_pkg::ST_TK_RD;
               default: state_in = imht_pkg::ST_IDLE;
            endcase
         end
         imht_pkg::ST_RM_A: state_in = imht_pkg::ST_RM_B;
         imht_pkg::ST_RM_B: state_in = imht_pkg::ST_DN_A;
         imht_pkg::ST_DN_A: begin
            state_in = status.j_ok ? imht_pkg::ST_DN_B : imht_pkg::ST_DN_END;
         end
         imht_pkg::ST_DN_B: state_in = imht_pkg::ST_DN_C;
         imht_pkg::ST_DN_C: begin
            state_in = status.child_win ? imht_pkg::ST_DN_A : imht_pkg::ST_DN_END;
         end
         imht_pkg::ST_DN_END: begin
            state_in = status.moved ? imht_pkg::ST_FIN : imht_pkg::ST_UP_A;
         end
         imht_pkg::ST_UP_A: begin
            state_in = status.i_zero ? imht_pkg::ST_FIN : imht_pkg::ST_UP_B;
         end
         imht_pkg::ST_UP_B: begin
            state_in = status.parent_win ? imht_pkg::ST_UP_A : imht_pkg::ST_FIN;
         end
         imht_pkg::ST_FIN: state_in = imht_pkg::ST_POST;
         imht_pkg::ST_POST: begin
            if (status.op == imht_pkg::OP_TICK || status.op == imht_pkg::OP_NEXT) begin
               state_in = imht_pkg::ST_TK_RD;
            end else begin
               state_in = imht_pkg::ST_IDLE;
            end
         end
         imht_pkg::ST_TK_RD: begin
            if (status.cnt_zero || !status.k_ok) state_in = imht_pkg::ST_TK_END;
            else                                 state_in = imht_pkg::ST_TK_CK;
         end
         imht_pkg::ST_TK_CK: begin
            if (!status.due)         state_in = imht_pkg::ST_TK_END;
            else if (status.cnt_gt1) state_in = imht_pkg::ST_RM_A;
            else                     state_in = imht_pkg::ST_TK_RD;
         end
         imht_pkg::ST_TK_END: begin
            state_in = (status.op == imht_pkg::OP_NEXT) ? imht_pkg::ST_GN_RD
                                                         : imht_pkg::ST_IDLE;
         end
         imht_pkg::ST_GN_RD: state_in = imht_pkg::ST_GN_RP;
         imht_pkg::ST_GN_RP: state_in = imht_pkg::ST_IDLE;
         default: state_in = imht_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         imht_pkg::ST_IDLE: begin
            cmd.accept = start;
         end
         imht_pkg::ST_LK_HEAP: begin
            cmd.pos_ld = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = imht_pkg::RD_POS;
         end
         imht_pkg::ST_LK_CHK: begin
            unique case (status.op) inside
               imht_pkg::OP_ADD, imht_pkg::OP_ADJUST: begin
                  if (status.present) begin
                     cmd.x_ld     = 1'b1;
                     cmd.xsrc     = imht_pkg::XS_REQ;
                     cmd.i_sel    = imht_pkg::I_POS;
                     cmd.start_ld = 1'b1;
                  end else if (status.op == imht_pkg::OP_ADJUST || status.full) begin
                     cmd.emit = 1'b1;
                     cmd.kind = imht_pkg::KIND_ERROR;
                     cmd.last = 1'b1;
                  end else begin
                     cmd.x_ld     = 1'b1;
                     cmd.xsrc     = imht_pkg::XS_REQ;
                     cmd.i_sel    = imht_pkg::I_CNT;
                     cmd.start_ld = 1'b1;
                     cmd.cnt_op   = imht_pkg::CNT_INC;
                  end
               end
               imht_pkg::OP_FIRE: begin
                  if (status.present) begin
                     cmd.i_sel    = imht_pkg::I_POS;
                     cmd.start_ld = 1'b1;
                     if (!status.tail) cmd.cnt_op = imht_pkg::CNT_DEC;
                  end else begin
                     cmd.emit = 1'b1;
                     cmd.kind = imht_pkg::KIND_DONE;
                     cmd.last = 1'b1;
                  end
               end
               imht_pkg::OP_TICK, imht_pkg::OP_NEXT: begin
                  cmd.k_clr    = 1'b1;
                  cmd.pend_clr = 1'b1;
               end
               imht_pkg::OP_CLEAR: begin
                  cmd.cnt_op = imht_pkg::CNT_CLR;
                  cmd.emit   = 1'b1;
                  cmd.kind   = imht_pkg::KIND_DONE;
                  cmd.last   = 1'b1;
               end
               default: begin
                  cmd.emit = 1'b1;
                  cmd.kind = imht_pkg::KIND_ERROR;
                  cmd.last = 1'b1;
               end
            endcase
         end
         imht_pkg::ST_RM_A: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = imht_pkg::RD_TAIL;
            cmd.cnt_op = imht_pkg::CNT_DEC;
         end
         imht_pkg::ST_RM_B: begin
            cmd.x_ld = 1'b1;
            cmd.xsrc = imht_pkg::XS_RDATA;
         end
         imht_pkg::ST_DN_A: begin
            cmd.rd_en  = status.j_ok;
            cmd.rd_sel = imht_pkg::RD_J;
         end
         imht_pkg::ST_DN_B: begin
            cmd.c_ld   = 1'b1;
            cmd.rd_en  = status.j1_ok;
            cmd.rd_sel = imht_pkg::RD_J1;
         end
         imht_pkg::ST_DN_C: begin
            if (status.child_win) begin
               cmd.wr_en = 1'b1;
               cmd.wsrc  = imht_pkg::WS_BEST;
               cmd.i_sel = imht_pkg::I_BEST;
            end
         end
         imht_pkg::ST_DN_END: begin
         end
         imht_pkg::ST_UP_A: begin
            cmd.rd_en  = !status.i_zero;
            cmd.rd_sel = imht_pkg::RD_PAR;
         end
         imht_pkg::ST_UP_B: begin
            if (status.parent_win) begin
               cmd.wr_en = 1'b1;
               cmd.wsrc  = imht_pkg::WS_PARENT;
               cmd.i_sel = imht_pkg::I_PAR;
            end
         end
         imht_pkg::ST_FIN: begin
            cmd.wr_en = 1'b1;
            cmd.wsrc  = imht_pkg::WS_X;
         end
         imht_pkg::ST_POST: begin
            if (status.op == imht_pkg::OP_FIRE) begin
               cmd.emit = 1'b1;
               cmd.kind = imht_pkg::KIND_EVENT;
               cmd.esrc = imht_pkg::ES_REQ;
               cmd.last = 1'b1;
            end else if (status.op == imht_pkg::OP_ADD || status.op == imht_pkg::OP_ADJUST) begin
               cmd.emit = 1'b1;
               cmd.kind = imht_pkg::KIND_DONE;
               cmd.last = 1'b1;
            end
         end
         imht_pkg::ST_TK_RD: begin
            cmd.rd_en  = !(status.cnt_zero || !status.k_ok);
            cmd.rd_sel = imht_pkg::RD_ROOT;
         end
         imht_pkg::ST_TK_CK: begin
            if (status.due) begin
               // the previous pop is now known not to be the final beat
               cmd.emit     = status.pend_v;
               cmd.kind     = imht_pkg::KIND_EVENT;
               cmd.esrc     = imht_pkg::ES_PEND;
               cmd.pend_ld  = 1'b1;
               cmd.k_inc    = 1'b1;
               cmd.i_sel    = imht_pkg::I_ROOT;
               cmd.start_ld = 1'b1;
               if (!status.cnt_gt1) cmd.cnt_op = imht_pkg::CNT_DEC;
            end
         end
         imht_pkg::ST_TK_END: begin
            cmd.emit = 1'b1;
            if (status.op == imht_pkg::OP_NEXT) begin
               cmd.emit = status.pend_v;
               cmd.kind = imht_pkg::KIND_EVENT;
               cmd.esrc = imht_pkg::ES_PEND;
            end else if (status.pend_v) begin
               cmd.kind = imht_pkg::KIND_EVENT;
               cmd.esrc = imht_pkg::ES_PEND;
               cmd.last = 1'b1;
            end else begin
               cmd.kind = imht_pkg::KIND_DONE;
               cmd.last = 1'b1;
            end
         end
         imht_pkg::ST_GN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = imht_pkg::RD_ROOT;
         end
         imht_pkg::ST_GN_RP: begin
            cmd.emit    = 1'b1;
            cmd.kind    = imht_pkg::KIND_REPORT;
            cmd.rem_rep = 1'b1;
            cmd.last    = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

/* hw/rtl/imht_dpath.sv */
// datapath of the timer queue: heap and position memories, sift registers,
// compares and the result register; depends on imht_pkg and imht_ram
module imht_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  imht_pkg::dp_cmd_type        cmd,
   output imht_pkg::dp_status_type     status,
   input  logic [imht_pkg::OP_W-1:0]   req_op,
   input  imht_pkg::id_type            req_timer_id,
   input  logic signed [imht_pkg::MS_W-1:0] req_timeout_ms,
   input  logic [imht_pkg::MS_W-1:0]   req_now_ms,
   output logic                        rsp_strobe,
   output logic [imht_pkg::KIND_W-1:0] rsp_event_kind,
   output imht_pkg::id_type            rsp_event_id,
   output logic signed [imht_pkg::MS_W-1:0] rsp_remaining_ms,
   output logic                        rsp_last
);

   localparam int TB = imht_pkg::TIME_BITS;

   logic [imht_pkg::OP_W-1:0] op_ff;
   imht_pkg::id_type          id_ff;
   imht_pkg::time_type        now_ff, exp_ff;
   imht_pkg::entry_type       x_ff, c_ff;
   imht_pkg::idx_type         i_ff, start_ff, pos_ff;
   imht_pkg::cnt_type         cnt_ff;
   imht_pkg::k_type           k_ff;
   logic                      pend_v_ff;
   imht_pkg::id_type          pend_id_ff;

   logic                      rsp_strobe_ff, rsp_last_ff;
   logic [imht_pkg::KIND_W-1:0] rsp_kind_ff;
   imht_pkg::id_type          rsp_id_ff;
   logic [imht_pkg::MS_W-1:0] rsp_rem_ff;

   logic [imht_pkg::ENTRY_W-1:0] heap_q, wdata;
   imht_pkg::idx_type            pos_q, raddr, i_in, par, best_idx;
   imht_pkg::entry_type          rdata, best, wentry, x_in;
   imht_pkg::cnt_type            j7, j1;
   imht_pkg::time_type           d, rep;
   imht_pkg::k_type              limit;
   logic                         pick1;

   assign rdata = imht_pkg::entry_type'(heap_q);

   // children and parent of the current slot
   assign j7  = {i_ff, 1'b1};
   assign j1  = j7 + imht_pkg::CNT_W'(1);
   assign par = imht_pkg::IDX_W'((i_ff - imht_pkg::IDX_W'(1)) >> 1);

   assign pick1    = status.j1_ok && imht_pkg::earlier(rdata.exp, c_ff.exp);
   assign best     = pick1 ? rdata : c_ff;
   assign best_idx = pick1 ? j1[imht_pkg::IDX_W-1:0] : j7[imht_pkg::IDX_W-1:0];

   assign d     = rdata.exp - now_ff;
   assign rep   = (cnt_ff == '0) ? '1 : (d[TB-1] ? '0 : d);
   assign limit = (op_ff == imht_pkg::OP_NEXT) ? imht_pkg::K_W'(imht_pkg::MAX_RESULTS - 1)
                                               : imht_pkg::K_W'(imht_pkg::MAX_RESULTS);

   always_comb begin
      status.op         = op_ff;
      // a position is only trusted when its slot holds the same id
      status.present    = ({1'b0, pos_ff} < cnt_ff) && (rdata.id == id_ff);
      status.full       = (cnt_ff == imht_pkg::CNT_W'(imht_pkg::CAPACITY));
      status.tail       = ({1'b0, pos_ff} < (cnt_ff - imht_pkg::CNT_W'(1)));
      status.cnt_zero   = (cnt_ff == '0);
      status.cnt_gt1    = (cnt_ff > imht_pkg::CNT_W'(1));
      status.j_ok       = (j7 < cnt_ff);
      status.j1_ok      = (j1 < cnt_ff);
      status.i_zero     = (i_ff == '0);
      status.child_win  = imht_pkg::earlier(best.exp, x_ff.exp);
      status.parent_win = imht_pkg::earlier(x_ff.exp, rdata.exp);
      status.moved      = (i_ff != start_ff);
      status.due        = (d == '0) || d[TB-1];
      status.k_ok       = (k_ff < limit);
      status.pend_v     = pend_v_ff;
   end

   always_comb begin
      case (cmd.rd_sel)
         imht_pkg::RD_POS:  raddr = pos_q;
         imht_pkg::RD_J:    raddr = j7[imht_pkg::IDX_W-1:0];
         imht_pkg::RD_J1:   raddr = j1[imht_pkg::IDX_W-1:0];
         imht_pkg::RD_PAR:  raddr = par;
         imht_pkg::RD_ROOT: raddr = '0;
         imht_pkg::RD_TAIL: raddr = imht_pkg::IDX_W'(cnt_ff - imht_pkg::CNT_W'(1));
         default:           raddr = '0;
      endcase
   end

   always_comb begin
      case (cmd.wsrc)
         imht_pkg::WS_BEST:   wentry = best;
         imht_pkg::WS_PARENT: wentry = rdata;
         imht_pkg::WS_X:      wentry = x_ff;
         default:             wentry = x_ff;
      endcase
   end

   assign wdata = wentry;

   always_comb begin
      case (cmd.i_sel)
         imht_pkg::I_BEST: i_in = best_idx;
         imht_pkg::I_PAR:  i_in = par;
         imht_pkg::I_POS:  i_in = pos_ff;
         imht_pkg::I_CNT:  i_in = cnt_ff[imht_pkg::IDX_W-1:0];
         imht_pkg::I_ROOT: i_in = '0;
         default:          i_in = i_ff;
      endcase
   end

   assign x_in = (cmd.xsrc == imht_pkg::XS_RDATA) ? rdata : '{id: id_ff, exp: exp_ff};

   imht_ram #(
      .WIDTH (imht_pkg::ENTRY_W),
      .DEPTH (imht_pkg::CAPACITY)
   ) u_heap (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (i_ff),
      .wr_data (wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (raddr),
      .rd_data (heap_q)
   );

   // every heap write also records the new slot of the moved id
   imht_ram #(
      .WIDTH (imht_pkg::IDX_W),
      .DEPTH (imht_pkg::ID_SPACE)
   ) u_pos (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wentry.id),
      .wr_data (i_ff),
      .rd_en   (cmd.accept),
      .rd_addr (req_timer_id),
      .rd_data (pos_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_op;
         id_ff  <= req_timer_id;
         now_ff <= imht_pkg::time_type'(req_now_ms);
         exp_ff <= imht_pkg::time_type'(req_now_ms)
                 + (req_timeout_ms[imht_pkg::MS_W-1] ? '0
                                                     : imht_pkg::time_type'(req_timeout_ms));
      end
      if (cmd.pos_ld)   pos_ff   <= pos_q;
      if (cmd.x_ld)     x_ff     <= x_in;
      if (cmd.c_ld)     c_ff     <= rdata;
      i_ff <= i_in;
      if (cmd.start_ld) start_ff <= i_in;
      if (cmd.k_clr)       k_ff <= '0;
      else if (cmd.k_inc)  k_ff <= k_ff + imht_pkg::K_W'(1);
      if (cmd.pend_ld)  pend_id_ff <= rdata.id;
      rsp_kind_ff <= cmd.kind;
      rsp_last_ff <= cmd.last;
      case (cmd.esrc)
         imht_pkg::ES_PEND: rsp_id_ff <= pend_id_ff;
         imht_pkg::ES_REQ:  rsp_id_ff <= id_ff;
         default:           rsp_id_ff <= '0;
      endcase
      rsp_rem_ff <= cmd.rem_rep ? imht_pkg::MS_W'(rep) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         pend_v_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
         if (cmd.pend_clr)     pend_v_ff <= 1'b0;
         else if (cmd.pend_ld) pend_v_ff <= 1'b1;
         case (cmd.cnt_op)
            imht_pkg::CNT_INC: cnt_ff <= cnt_ff + imht_pkg::CNT_W'(1);
            imht_pkg::CNT_DEC: cnt_ff <= cnt_ff - imht_pkg::CNT_W'(1);
            imht_pkg::CNT_CLR: cnt_ff <= '0;
            default:           cnt_ff <= cnt_ff;
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_event_id     = rsp_id_ff;
   assign rsp_remaining_ms = signed'(rsp_rem_ff);
   assign rsp_last         = rsp_last_ff;

endmodule

/* hw/rtl/indexed_min_heap_timer.sv */
// keyed timer queue: binary min-heap of expiry times with an id-to-slot map
// top level; depends on imht_pkg, imht_ctrl, imht_dpath
//
// Usage. A command beat is taken when start is high and busy is low; busy then
// stays high until the command is finished. Results come back one per cycle
// at most, each shown for exactly one cycle with rsp_strobe high, and the
// final result of a command has rsp_last set. The receiver cannot stall, so
// results are never held back.
// Sequence: the slot map is read in the accept cycle, then the busy states
// LK_HEAP and LK_CHK read the heap slot and compare; commands that leave the
// heap alone end there. A sift walks down through DN_A, DN_B and DN_C per level
// and up through UP_A and UP_B per level, and a finish adds the write state FIN
// and the result state POST. A tick checks the root of each timer in TK_RD and
// TK_CK, then removes it and sifts while others remain, and closes in TK_END;
// get-next adds the report states GN_RD and GN_RP. Each result appears in the
// cycle after the state that makes it. The heap memory has a single read port;
// one command is in flight at a time.
// Reset: synchronous, active high; the queue comes out empty and no clearing
// pass runs, since a slot map entry only counts when the heap slot it names
// lies below the fill count and holds the same id.
module indexed_min_heap_timer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [imht_pkg::OP_W-1:0]   req_op,
   input  imht_pkg::id_type            req_timer_id,
   input  logic signed [imht_pkg::MS_W-1:0] req_timeout_ms,
   input  logic [imht_pkg::MS_W-1:0]   req_now_ms,
   output logic                        rsp_strobe,
   output logic [imht_pkg::KIND_W-1:0] rsp_event_kind,
   output imht_pkg::id_type            rsp_event_id,
   output logic signed [imht_pkg::MS_W-1:0] rsp_remaining_ms,
   output logic                        rsp_last
);

   imht_pkg::dp_cmd_type    cmd;
   imht_pkg::dp_status_type status;

   imht_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   imht_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_timer_id     (req_timer_id),
      .req_timeout_ms   (req_timeout_ms),
      .req_now_ms       (req_now_ms),
      .rsp_strobe       (rsp_strobe),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_id     (rsp_event_id),
      .rsp_remaining_ms (rsp_remaining_ms),
      .rsp_last         (rsp_last)
   );

endmodule

/* hw/rtl/imht_checker.sv */
// port-level checks of the timer queue, bound to the top level
// depends on imht_pkg and indexed_min_heap_timer_defines.svh
`include "indexed_min_heap_timer_defines.svh"

module imht_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic [imht_pkg::KIND_W-1:0] rsp_event_kind,
   input imht_pkg::id_type            rsp_event_id,
   input logic signed [imht_pkg::MS_W-1:0] rsp_remaining_ms,
   input logic                        rsp_last
);

   // a command beat always makes the block busy in the next cycle
   `IMHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !rsp_strobe, "accept not followed by busy")
   // more beats to come means the command is still running
   `IMHT_ASSERT_SAME(a_more_busy, rsp_strobe && !rsp_last, busy, "non-final beat while idle")
   // only expiry beats carry an id
   `IMHT_ASSERT_SAME(a_id_zero, rsp_strobe && rsp_event_kind != imht_pkg::KIND_EVENT, rsp_event_id == '0, "id on non-event beat")
   // the report closes get-next and is never below minus one
   `IMHT_ASSERT_SAME(a_report_last, rsp_strobe && rsp_event_kind == imht_pkg::KIND_REPORT, rsp_last && (rsp_remaining_ms >= -1), "bad next-tick report")

endmodule

bind indexed_min_heap_timer imht_checker u_imht_checker (.*);
